FILE: design/generational_handle_allocator_macros.svh
// Assertion macros for the generational handle allocator.
// Used by design/gha_core.sv; expects clk and arst_n in scope.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define GHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// No dependencies; imported by gha_core and generational_handle_allocator.
package gha_pkg;

	localparam int SLOTS    = 256;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int GEN_BITS = 32;

	localparam logic [GEN_BITS-1:0] GEN_INVALID = '1;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_RELEASE = 2'd2,
		OP_RSVD    = 2'd3
	} gha_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_STALE = 2'd1,
		ST_FULL  = 2'd2,
		ST_BAD   = 2'd3
	} gha_status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} gha_state_t;

	typedef struct packed {
		gha_op_t             op;
		logic [IDX_W-1:0]    idx;
		logic [GEN_BITS-1:0] gen;
	} gha_req_t;

	typedef struct packed {
		gha_status_t         status;
		logic [IDX_W-1:0]    idx;
		logic [GEN_BITS-1:0] gen;
	} gha_resp_t;

	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		if (p == IDX_W'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = p + IDX_W'(1);
		end
		return r;
	endfunction

endpackage

FILE: design/generational_handle_allocator.sv
// Generational handle allocator: one registered result per transfer.
// An input transfer is accepted while the block is idle; the result is in the output
// register and m_axis_tvalid is high once the execute state can hand it over.
// A new item is taken only after the last one's slot table read and write-back are done.
// The input may be accepted while an earlier result still waits in the output register.
// Reset (arst_n low, asynchronous): counters, pointers and valids clear; tables are not cleared.
//
// Depends on gha_pkg and gha_core.

module generational_handle_allocator import gha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [7:0] handle_index, [39:8] handle_generation
	input  logic [1:0]  s_axis_tuser,   // [1:0] operation
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] slot_index, [39:8] slot_generation
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	gha_req_t  req;
	gha_resp_t resp;
	logic      resp_valid;
	logic      resp_ready;

	// output register state
	logic      m_valid_q;
	gha_resp_t m_resp_q;

	assign req.op  = gha_op_t'(s_axis_tuser);
	assign req.idx = s_axis_tdata[IDX_W-1:0];
	assign req.gen = s_axis_tdata[IDX_W +: GEN_BITS];

	gha_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_axis_tvalid),
		.req_ready  (s_axis_tready),
		.req        (req),
		.resp_valid (resp_valid),
		.resp_ready (resp_ready),
		.resp       (resp)
	);

	// the core finishes an item only when the output register can take it
	assign resp_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (resp_ready) begin
			m_valid_q <= resp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_ready && resp_valid) m_resp_q <= resp;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_resp_q.status;
	assign m_axis_tdata  = {m_resp_q.gen, m_resp_q.idx};

endmodule

FILE: design/gha_core.sv
// Slot generation table, free-slot FIFO and the read-modify-write sequencer.
// Depends on gha_pkg and generational_handle_allocator_macros.svh.
`include "generational_handle_allocator_macros.svh"

module gha_core import gha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  gha_req_t  req,
	output logic      resp_valid,
	input  logic      resp_ready,
	output gha_resp_t resp
);

	gha_state_t state_q, state_d;

	gha_op_t             op_q;
	logic [IDX_W-1:0]    idx_q;
	logic [GEN_BITS-1:0] hgen_q;

	logic [IDX_W:0]      used_q;
	logic [IDX_W:0]      free_cnt_q;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    tail_q;
	logic [GEN_BITS-1:0] gen_ctr_q;

	logic [GEN_BITS-1:0] gen_mem [SLOTS];
	logic [IDX_W-1:0]    fifo_mem [SLOTS];
	logic [GEN_BITS-1:0] gen_rd_q;
	logic [IDX_W-1:0]    fifo_rd_q;

	logic                accept;
	logic                commit;
	logic                full;
	logic                in_use;
	logic                live;
	logic [GEN_BITS-1:0] gen_new;
	logic [IDX_W-1:0]    alloc_slot;
	logic                do_alloc;
	logic                do_release;
	logic                gen_we;
	logic [IDX_W-1:0]    gen_wa;
	logic [GEN_BITS-1:0] gen_wd;

	assign accept = req_valid && req_ready;
	assign commit = (state_q == S_EXEC) && resp_ready;

	// FSM: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (resp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// FSM: outputs
	always_comb begin
		req_ready  = 1'b0;
		resp_valid = 1'b0;
		case (state_q)
			S_IDLE:  req_ready  = 1'b1;
			S_EXEC:  resp_valid = 1'b1;
			default: req_ready  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			idx_q  <= req.idx;
			hgen_q <= req.gen;
		end
	end

	// synchronous reads, issued on accept; data holds while the result stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			gen_rd_q  <= gen_mem[req.idx];
			fifo_rd_q <= fifo_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (gen_we) gen_mem[gen_wa] <= gen_wd;
	end

	always_ff @(posedge clk) begin
		if (do_release) fifo_mem[tail_q] <= idx_q;
	end

	// decode of the held item
	assign full       = (free_cnt_q == '0) && (used_q == (IDX_W+1)'(SLOTS));
	assign gen_new    = (gen_ctr_q == GEN_INVALID) ? '0 : gen_ctr_q;
	assign alloc_slot = (free_cnt_q != '0) ? fifo_rd_q : used_q[IDX_W-1:0];
	assign in_use     = {1'b0, idx_q} < used_q;
	assign live       = in_use && (gen_rd_q != GEN_INVALID);
	assign do_alloc   = commit && (op_q == OP_ALLOC) && !full;
	assign do_release = commit && (op_q == OP_RELEASE) && live;

	assign gen_we = do_alloc || do_release;
	assign gen_wa = do_alloc ? alloc_slot : idx_q;
	assign gen_wd = do_alloc ? gen_new : GEN_INVALID;

	always_comb begin
		resp.status = ST_BAD;
		resp.idx    = idx_q;
		resp.gen    = '0;
		case (op_q)
			OP_ALLOC: begin
				if (full) begin
					resp.status = ST_FULL;
					resp.idx    = '0;
				end else begin
					resp.status = ST_OK;
					resp.idx    = alloc_slot;
					resp.gen    = gen_new;
				end
			end
			OP_LOOKUP: begin
				resp.status = (live && (gen_rd_q == hgen_q)) ? ST_OK : ST_STALE;
			end
			OP_RELEASE: begin
				resp.status = live ? ST_OK : ST_BAD;
			end
			default: resp.status = ST_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			free_cnt_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			gen_ctr_q  <= '0;
		end else begin
			if (do_alloc) begin
				gen_ctr_q <= gen_new + GEN_BITS'(1);
				if (free_cnt_q != '0) begin
					head_q <= ptr_inc(head_q);
				end else begin
					used_q <= used_q + (IDX_W+1)'(1);
				end
			end
			if (do_release) tail_q <= ptr_inc(tail_q);
			case ({do_alloc && (free_cnt_q != '0), do_release})
				2'b10:   free_cnt_q <= free_cnt_q - (IDX_W+1)'(1);
				2'b01:   free_cnt_q <= free_cnt_q + (IDX_W+1)'(1);
				default: free_cnt_q <= free_cnt_q;
			endcase
		end
	end

	`GHA_ASSERT_IMP(a_free_le_used, 1'b1, free_cnt_q <= used_q, "free count exceeds used slots")
	`GHA_ASSERT_IMP(a_used_bound, 1'b1, used_q <= (IDX_W+1)'(SLOTS), "used slots beyond table")
	`GHA_ASSERT_IMP(a_fifo_ptrs, 1'b1, (tail_q - head_q) == free_cnt_q[IDX_W-1:0], "fifo pointers disagree with count")
	`GHA_ASSERT_IMP(a_gen_valid, do_alloc, gen_new != GEN_INVALID, "reserved generation handed out")
	`GHA_ASSERT_NXT(a_one_item, commit, req_ready && !resp_valid, "sequencer did not return to idle")

endmodule
